// ----- design/ispsl_pkg.sv -----
// Package for the integral-separation PID speed loop: constants, register codes, direction codes.
package ispsl_pkg;

   localparam int INTEGRAL_WIDTH_DEF = 24;

   localparam int GAIN_W  = 16;
   localparam int LIMIT_W = 8;
   localparam int CMD_W   = 16;
   localparam int MEAS_W  = 9;
   localparam int ERR_W   = 10;
   localparam int CMP_W   = 10;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CMP_W-1:0] DUTY_MAX      = 10'd980;
   localparam logic [CMP_W-1:0] BRAKE_COMPARE = 10'd999;

   localparam logic [GAIN_W-1:0]  KP_RESET        = 16'd9216;
   localparam logic [GAIN_W-1:0]  KI_RESET        = 16'd307;
   localparam logic [GAIN_W-1:0]  KD_RESET        = 16'd256;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 8'd15;
   localparam logic [LIMIT_W-1:0] THRESHOLD_RESET = 8'd5;

   typedef enum logic [1:0] {
      DIR_FORWARD = 2'd0,
      DIR_REVERSE = 2'd1,
      DIR_BRAKE   = 2'd2
   } dir_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP_FORWARD  = 3'd0,
      CSR_KI_FORWARD  = 3'd1,
      CSR_KD_FORWARD  = 3'd2,
      CSR_KP_REVERSE  = 3'd3,
      CSR_KI_REVERSE  = 3'd4,
      CSR_KD_REVERSE  = 3'd5,
      CSR_SPEED_LIMIT = 3'd6,
      CSR_INTEG_THRES = 3'd7
   } csr_index_type;

endpackage

// ----- design/integral_separation_pid_speed_loop_unit.sv -----
// Integral-separation PID speed loop: input register, combinational PID update, result register.
//
//   channel | direction | transfer when          | payload
//   req_    | in        | req_tvalid & tready    | tdata: target_speed, measured_speed
//   rsp_    | out       | rsp_tvalid & tready    | tdata: forward/reverse compare; tuser: dir
//   csr_    | in        | csr_we                 | csr_index, csr_wdata
//
// Sustained throughput: one item per cycle while rsp_ is not stalled.
// The PID update (gain products, integral saturate, duty clamp) is combinational logic
// between the input register and the result register; it also commits the loop state.
// A stalled rsp_ holds the result; the input register keeps one more item, then req_tready drops.
// Synchronous reset clears valids and loop state, and loads the default gains, limit and threshold.
module integral_separation_pid_speed_loop_unit
   import ispsl_pkg::*;
#(
   parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] target_speed, [24:16] measured_speed
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [9:0] forward_compare, [19:10] reverse_compare
   output logic [1:0]            rsp_tuser,   // [1:0] drive_direction
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IW    = INTEGRAL_WIDTH;
   localparam int SUM_W = IW + GAIN_W + 3;

   // configuration
   logic [GAIN_W-1:0]  kp_fwd_ff, ki_fwd_ff, kd_fwd_ff;
   logic [GAIN_W-1:0]  kp_rev_ff, ki_rev_ff, kd_rev_ff;
   logic [LIMIT_W-1:0] limit_ff, thres_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_fwd_ff <= KP_RESET;
         ki_fwd_ff <= KI_RESET;
         kd_fwd_ff <= KD_RESET;
         kp_rev_ff <= KP_RESET;
         ki_rev_ff <= KI_RESET;
         kd_rev_ff <= KD_RESET;
         limit_ff  <= LIMIT_RESET;
         thres_ff  <= THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_KP_FORWARD:  kp_fwd_ff <= csr_wdata;
            CSR_KI_FORWARD:  ki_fwd_ff <= csr_wdata;
            CSR_KD_FORWARD:  kd_fwd_ff <= csr_wdata;
            CSR_KP_REVERSE:  kp_rev_ff <= csr_wdata;
            CSR_KI_REVERSE:  ki_rev_ff <= csr_wdata;
            CSR_KD_REVERSE:  kd_rev_ff <= csr_wdata;
            CSR_SPEED_LIMIT: limit_ff  <= csr_wdata[LIMIT_W-1:0];
            CSR_INTEG_THRES: thres_ff  <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   logic in_valid_ff, out_valid_ff;
   logic out_free, advance;
   logic [CMD_W-1:0]  tgt_ff;
   logic [MEAS_W-1:0] meas_ff;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign rsp_tvalid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         tgt_ff  <= req_tdata[CMD_W-1:0];
         meas_ff <= req_tdata[CMD_W+MEAS_W-1:CMD_W];
      end
   end

   // loop state
   logic signed [IW-1:0]    integ_ff, integ_in;
   logic signed [ERR_W-1:0] prev_err_ff;

   // PID datapath
   dir_type                   dir;
   logic [CMD_W:0]            tgt_mag;
   logic [LIMIT_W-1:0]        setp;
   logic signed [ERR_W-1:0]   meas_x, lim_x, err;
   logic [ERR_W-1:0]          err_mag;
   logic                      enabled, add;
   logic signed [IW:0]        integ_sum;
   logic signed [IW-1:0]      integ_sat, integ_use;
   logic signed [ERR_W:0]     err_diff;
   logic [GAIN_W-1:0]         kp, ki, kd;
   logic signed [GAIN_W+ERR_W:0]   p_prod;
   logic signed [GAIN_W+ERR_W+1:0] d_prod;
   logic signed [GAIN_W+IW:0]      i_prod;
   logic signed [SUM_W-1:0]   pid_sum;
   logic [SUM_W-9:0]          pid_q;
   logic [CMP_W-1:0]          duty;

   always_comb begin
      priority if (!tgt_ff[CMD_W-1] && (tgt_ff != '0)) begin
         dir     = DIR_FORWARD;
         tgt_mag = {1'b0, tgt_ff};
      end else if (tgt_ff[CMD_W-1]) begin
         dir     = DIR_REVERSE;
         tgt_mag = (CMD_W+1)'(0) - {tgt_ff[CMD_W-1], tgt_ff};
      end else begin
         dir     = DIR_BRAKE;
         tgt_mag = '0;
      end

      setp = (tgt_mag >= {{(CMD_W+1-LIMIT_W){1'b0}}, limit_ff}) ?
             limit_ff : tgt_mag[LIMIT_W-1:0];

      meas_x  = {meas_ff[MEAS_W-1], meas_ff};
      lim_x   = {2'b00, limit_ff};
      err     = $signed({2'b00, setp}) - meas_x;
      err_mag = err[ERR_W-1] ? ERR_W'(0) - err : err;
      enabled = err_mag <= {2'b00, thres_ff};

      priority if (meas_x > lim_x) begin
         add = err[ERR_W-1];
      end else if (meas_x < -lim_x) begin
         add = !err[ERR_W-1] && (err != '0);
      end else begin
         add = 1'b1;
      end

      integ_sum = (IW+1)'(integ_ff) + (IW+1)'(err);
      priority if (integ_sum[IW] != integ_sum[IW-1]) begin
         integ_sat = integ_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
      end else begin
         integ_sat = integ_sum[IW-1:0];
      end
      integ_in  = (enabled && add) ? integ_sat : integ_ff;
      integ_use = enabled ? integ_in : '0;

      err_diff = (ERR_W+1)'(err) - (ERR_W+1)'(prev_err_ff);

      if (dir == DIR_FORWARD) begin
         kp = kp_fwd_ff;
         ki = ki_fwd_ff;
         kd = kd_fwd_ff;
      end else begin
         kp = kp_rev_ff;
         ki = ki_rev_ff;
         kd = kd_rev_ff;
      end

      p_prod  = $signed({1'b0, kp}) * err;
      d_prod  = $signed({1'b0, kd}) * err_diff;
      i_prod  = $signed({1'b0, ki}) * integ_use;
      pid_sum = SUM_W'(p_prod) + SUM_W'(d_prod) + SUM_W'(i_prod);
      pid_q   = pid_sum[SUM_W-1:8];

      priority if (pid_sum[SUM_W-1] || (pid_sum == '0)) begin
         duty = '0;
      end else if (pid_q > (SUM_W-8)'(DUTY_MAX)) begin
         duty = DUTY_MAX;
      end else begin
         duty = pid_q[CMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         prev_err_ff <= '0;
      end else if (advance) begin
         integ_ff    <= integ_in;
         prev_err_ff <= err;
      end
   end

   // result register
   logic [CMP_W-1:0] fwd_cmp_ff, rev_cmp_ff;
   dir_type          dir_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         dir_ff <= dir;
         unique case (dir)
            DIR_FORWARD: begin
               fwd_cmp_ff <= duty;
               rev_cmp_ff <= '0;
            end
            DIR_REVERSE: begin
               fwd_cmp_ff <= '0;
               rev_cmp_ff <= duty;
            end
            default: begin
               fwd_cmp_ff <= BRAKE_COMPARE;
               rev_cmp_ff <= BRAKE_COMPARE;
            end
         endcase
      end
   end

   assign rsp_tdata = {{(RSP_DATA_W-2*CMP_W){1'b0}}, rev_cmp_ff, fwd_cmp_ff};
   assign rsp_tuser = dir_ff;

   // checks
   a_brake_cmp: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && dir_ff == DIR_BRAKE) |->
      (fwd_cmp_ff == BRAKE_COMPARE && rev_cmp_ff == BRAKE_COMPARE))
      else $error("brake result without full compares");

   a_fwd_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && dir_ff == DIR_FORWARD) |->
      (rev_cmp_ff == '0 && fwd_cmp_ff <= DUTY_MAX))
      else $error("forward result out of range");

   a_rev_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && dir_ff == DIR_REVERSE) |->
      (fwd_cmp_ff == '0 && rev_cmp_ff <= DUTY_MAX))
      else $error("reverse result out of range");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(integ_ff) && $stable(prev_err_ff)))
      else $error("loop state changed without a transfer");

   a_item_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> in_valid_ff)
      else $error("pending item lost under stall");

endmodule

// ----- tb/pid_drive_check.sv -----
`timescale 1ns / 1ps
// Speed loop monitor: tracks register writes, predicts each drive result and compares it.
module pid_drive_check
   import ispsl_pkg::*;
#(
   parameter int INTEGRAL_W = INTEGRAL_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [1:0]            rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    drives_due,
   output int                    drive_faults
);

   typedef struct packed {
      logic [CMP_W-1:0] fwd_cmp;
      logic [CMP_W-1:0] rev_cmp;
      dir_type          dir;
   } drive_type;

   logic [GAIN_W-1:0]  kp_fwd, ki_fwd, kd_fwd, kp_rev, ki_rev, kd_rev;
   logic [LIMIT_W-1:0] speed_cap, integ_band;
   longint             integ_acc;
   int                 last_err;
   drive_type          pending_drives[$];
   drive_type          got, want;
   int                 result_no;

   initial begin
      drives_due   = 0;
      drive_faults = 0;
      result_no    = 0;
   end

   // one loop update; advances the integrator and the stored error
   function automatic drive_type predict_drive(logic [CMD_W-1:0] cmd_raw,
                                               logic [MEAS_W-1:0] meas_raw);
      int        cmd, meas, setp, err, mag, lim;
      bit        integ_on, relieves;
      longint    kp, ki, kd, hi, acc, sum, duty;
      drive_type d;
      cmd  = $signed(cmd_raw);
      meas = $signed(meas_raw);
      lim  = speed_cap;
      if (cmd > 0) begin
         d.dir = DIR_FORWARD;
         setp  = cmd;
      end else if (cmd < 0) begin
         d.dir = DIR_REVERSE;
         setp  = -cmd;
      end else begin
         d.dir = DIR_BRAKE;
         setp  = 0;
      end
      if (setp > lim) setp = lim;
      err      = setp - meas;
      mag      = (err < 0) ? -err : err;
      integ_on = (mag <= int'(integ_band));
      if (meas > lim) relieves = (err < 0);
      else if (meas < -lim) relieves = (err > 0);
      else relieves = 1'b1;
      if (integ_on && relieves) begin
         hi  = (longint'(1) <<< (INTEGRAL_W - 1)) - 1;
         acc = integ_acc + err;
         if (acc > hi) acc = hi;
         else if (acc < -hi - 1) acc = -hi - 1;
         integ_acc = acc;
      end
      if (d.dir == DIR_FORWARD) begin
         kp = kp_fwd;
         ki = ki_fwd;
         kd = kd_fwd;
      end else begin
         kp = kp_rev;
         ki = ki_rev;
         kd = kd_rev;
      end
      sum = kp * err + kd * (err - last_err);
      if (integ_on) sum += ki * integ_acc;
      last_err = err;
      duty = (sum <= 0) ? 0 : sum / 256;
      if (duty > longint'(DUTY_MAX)) duty = DUTY_MAX;
      case (d.dir)
         DIR_FORWARD: begin
            d.fwd_cmp = duty[CMP_W-1:0];
            d.rev_cmp = '0;
         end
         DIR_REVERSE: begin
            d.fwd_cmp = '0;
            d.rev_cmp = duty[CMP_W-1:0];
         end
         default: begin
            d.fwd_cmp = BRAKE_COMPARE;
            d.rev_cmp = BRAKE_COMPARE;
         end
      endcase
      return d;
   endfunction

   task automatic report_mismatch(string note);
      $display("ERROR: drive result %0d: %s", result_no, note);
      drive_faults++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         kp_fwd     = KP_RESET;
         ki_fwd     = KI_RESET;
         kd_fwd     = KD_RESET;
         kp_rev     = KP_RESET;
         ki_rev     = KI_RESET;
         kd_rev     = KD_RESET;
         speed_cap  = LIMIT_RESET;
         integ_band = THRESHOLD_RESET;
         integ_acc  = 0;
         last_err   = 0;
         pending_drives.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.fwd_cmp = rsp_tdata[CMP_W-1:0];
            got.rev_cmp = rsp_tdata[2*CMP_W-1:CMP_W];
            got.dir     = dir_type'(rsp_tuser);
            if (pending_drives.size() == 0) begin
               report_mismatch("transfer with no result due");
            end else begin
               want = pending_drives.pop_front();
               if (got.fwd_cmp !== want.fwd_cmp)
                  report_mismatch($sformatf("forward_compare %0d, expected %0d",
                                            got.fwd_cmp, want.fwd_cmp));
               if (got.rev_cmp !== want.rev_cmp)
                  report_mismatch($sformatf("reverse_compare %0d, expected %0d",
                                            got.rev_cmp, want.rev_cmp));
               if (got.dir !== want.dir)
                  report_mismatch($sformatf("drive_direction %0d, expected %0d",
                                            got.dir, want.dir));
            end
            result_no++;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_KP_FORWARD:  kp_fwd     = csr_wdata;
               CSR_KI_FORWARD:  ki_fwd     = csr_wdata;
               CSR_KD_FORWARD:  kd_fwd     = csr_wdata;
               CSR_KP_REVERSE:  kp_rev     = csr_wdata;
               CSR_KI_REVERSE:  ki_rev     = csr_wdata;
               CSR_KD_REVERSE:  kd_rev     = csr_wdata;
               CSR_SPEED_LIMIT: speed_cap  = csr_wdata[LIMIT_W-1:0];
               CSR_INTEG_THRES: integ_band = csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            pending_drives.push_back(predict_drive(req_tdata[CMD_W-1:0],
                                                   req_tdata[CMD_W +: MEAS_W]));
      end
      drives_due <= pending_drives.size();
   end

endmodule

// ----- tb/integral_separation_pid_speed_loop_unit_test.sv -----
`timescale 1ns / 1ps
// Speed loop testbench top: clock, reset, register phases, speed commands and verdict.
module integral_separation_pid_speed_loop_unit_test;
   import ispsl_pkg::*;

   // integrator width of the default build
   localparam int LOOP_INTEG_W = INTEGRAL_WIDTH_DEF;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int drives_due, drive_faults;
   int sent_items    = 0;
   int send_idle_pct = 37;
   int recv_idle_pct = 48;
   int cur_limit     = LIMIT_RESET;
   int cur_band      = THRESHOLD_RESET;

   integral_separation_pid_speed_loop_unit #(.INTEGRAL_WIDTH(LOOP_INTEG_W)) uut (.*);

   pid_drive_check #(.INTEGRAL_W(LOOP_INTEG_W)) drive_check (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic csr_write(csr_index_type idx, int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
   endtask

   task automatic load_regs(int kpf, int kif, int kdf, int kpr, int kir, int kdr,
                            int lim, int band);
      csr_write(CSR_KP_FORWARD, kpf);
      csr_write(CSR_KI_FORWARD, kif);
      csr_write(CSR_KD_FORWARD, kdf);
      csr_write(CSR_KP_REVERSE, kpr);
      csr_write(CSR_KI_REVERSE, kir);
      csr_write(CSR_KD_REVERSE, kdr);
      csr_write(CSR_SPEED_LIMIT, lim);
      csr_write(CSR_INTEG_THRES, band);
      csr_we    <= 1'b0;
      cur_limit = lim;
      cur_band  = band;
   endtask

   function automatic int pick_gain(int typical);
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 65535;
         default: return $urandom_range(0, typical);
      endcase
   endfunction

   task automatic send_item(int target, int meas);
      logic [REQ_DATA_W-1:0] word;
      if (sent_items == 220) begin
         send_idle_pct = 48;
         recv_idle_pct = 37;
      end else if (sent_items == 440) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      word                    = '0;
      word[CMD_W-1:0]         = target[CMD_W-1:0];
      word[CMD_W +: MEAS_W]   = meas[MEAS_W-1:0];
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   // hold off until every transfer in flight has produced its result
   task automatic wait_drained;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (drives_due != 0);
   endtask

   task automatic random_items(int count);
      int kind, mag, setp, target, meas;
      repeat (count) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            // command near the limit, speed tracking it closely
            mag    = $urandom_range(0, cur_limit + 4);
            target = ($urandom_range(0, 19) == 0) ? 0 : ($urandom_range(0, 1) ? mag : -mag);
            setp   = (target == 0) ? 0 : ((mag > cur_limit) ? cur_limit : mag);
            meas   = setp + $urandom_range(0, 2 * cur_band + 4) - cur_band - 2;
            if (meas > 128) meas = 128;
            if (meas < -128) meas = -128;
         end else if (kind < 85) begin
            target = $urandom_range(0, 65535) - 32768;
            meas   = $urandom_range(0, 256) - 128;
         end else begin
            target = $urandom_range(0, 1) ? 32767 : -32768;
            meas   = $urandom_range(0, 256) - 128;
         end
         send_item(target, meas);
      end
   endtask

   initial begin
      int target, meas;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default gains
      send_item(0, 0);
      send_item(32767, 0);
      send_item(-32768, 0);
      send_item(1, 0);
      send_item(-1, 0);
      send_item(5, 0);
      send_item(6, 0);
      send_item(1, 128);
      send_item(-1, -128);
      send_item(15, 20);
      send_item(16, 15);
      wait_drained;

      // largest gains and band, limit 128
      load_regs(65535, 65535, 65535, 65535, 65535, 65535, 128, 255);
      send_item(128, -128);
      send_item(127, -128);
      send_item(-200, 128);
      send_item(0, 128);
      send_item(0, -128);
      wait_drained;

      // zero gains, limit zero, band zero
      load_regs(0, 0, 0, 0, 0, 0, 0, 0);
      send_item(100, 0);
      send_item(-5, -3);
      send_item(32767, 128);
      send_item(0, 0);
      wait_drained;

      // sustained large error winds up the integrator
      load_regs(pick_gain(2000), pick_gain(64), pick_gain(512),
                pick_gain(2000), pick_gain(64), pick_gain(512), 128, 255);
      repeat (160) begin
         target = $urandom_range(120, 128);
         meas   = target - 255 + $urandom_range(0, 25);
         if (meas < -128) meas = -128;
         send_item(($urandom_range(0, 3) == 0) ? -target : target, meas);
      end
      wait_drained;

      repeat (7) begin
         load_regs(pick_gain(20000), pick_gain(2000), pick_gain(4000),
                   pick_gain(20000), pick_gain(2000), pick_gain(4000),
                   $urandom_range(0, 128),
                   ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 30));
         random_items(70);
         wait_drained;
      end

      repeat (8) @(posedge clock);
      if (drive_faults == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
